// File: rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package u2u_pkg;

  // Lead byte class limits
  localparam logic [7:0]  AsciiMax    = 8'h7F;
  localparam logic [7:0]  Lead2Max    = 8'hDF;
  localparam logic [7:0]  Lead3Max    = 8'hEF;
  localparam logic [15:0] SkipMax     = 16'hFFFF;

  // Continuation bytes still awaited
  typedef enum logic [1:0] {
    PendNone = 2'd0,
    PendOne  = 2'd1,
    PendTwo  = 2'd2
  } pend_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic        code_valid;
    logic [15:0] code_unit;
    logic [15:0] skip_count;
  } out_beat_t;

endpackage

// File: rtl/u2u_in_reg.sv
// Input register stage: holds one accepted byte beat until the decoder takes it.
`timescale 1ns / 1ps

module u2u_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u2u_pkg::in_beat_t  in_data_i,
  output logic               beat_valid_o,
  input  logic               beat_take_i,
  output u2u_pkg::in_beat_t  beat_o
);
  import u2u_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t data_q;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready_o = !valid_q || beat_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = data_q;

endmodule

// File: rtl/u2u_core.sv
// Decode core: sequence state, partial code unit and dropped-lead counter.
`timescale 1ns / 1ps

module u2u_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  u2u_pkg::in_beat_t  beat_i,
  output u2u_pkg::out_beat_t result_o
);
  import u2u_pkg::*;

  pend_e       pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic [15:0] skip_q, skip_d;
  logic        unit_vld;
  logic [15:0] unit;

  // Decode one byte against the current sequence state
  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    skip_d   = skip_q;
    unit_vld = 1'b0;
    unit     = '0;
    unique case (pend_q)
      PendNone: begin
        if (beat_i.data_byte <= AsciiMax) begin
          unit_vld = 1'b1;
          unit     = {8'h00, beat_i.data_byte};
        end else if (beat_i.data_byte <= Lead2Max) begin
          part_d = {5'b0, beat_i.data_byte[4:0], 6'b0};
          pend_d = PendOne;
        end else if (beat_i.data_byte <= Lead3Max) begin
          part_d = {beat_i.data_byte[3:0], 12'b0};
          pend_d = PendTwo;
        end else if (skip_q != SkipMax) begin
          skip_d = skip_q + 16'd1;
        end
      end
      PendOne: begin
        unit_vld = 1'b1;
        unit     = part_q + {10'b0, beat_i.data_byte[5:0]};
        part_d   = '0;
        pend_d   = PendNone;
      end
      default: begin
        part_d = part_q | {4'b0, beat_i.data_byte[5:0], 6'b0};
        pend_d = PendOne;
      end
    endcase
    // Drop an unfinished sequence at end of stream
    if (beat_i.last && pend_d != PendNone) begin
      pend_d = PendNone;
      part_d = '0;
    end
  end

  always_comb begin
    result_o.code_valid = unit_vld;
    result_o.code_unit  = unit;
    result_o.skip_count = skip_d;
  end

  // Advance state only when a beat moves on to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
      part_q <= '0;
      skip_q <= '0;
    end else if (fire_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: rtl/u2u_out_reg.sv
// Result register stage: holds one decoded beat until the consumer takes it.
`timescale 1ns / 1ps

module u2u_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  u2u_pkg::out_beat_t  res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u2u_pkg::out_beat_t  out_data_o
);
  import u2u_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t data_q;

  // Load when empty or when the held beat is taken this cycle
  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o | in_data_i  (data_byte, last)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (code_valid, code_unit,
//           |           |                       |             skip_count)
//
// Every input beat yields exactly one output beat, via the input and result registers.
// One beat per cycle is sustained unless out stalls: the input register feeds
// the decode logic, and the result register loads in the same cycle the state advances.
// Backpressure on out stalls the result register, then the input register.
// Reset clears the sequence state, the dropped-lead counter and both valid flags.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u2u_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output u2u_pkg::out_beat_t out_data_o
);
  import u2u_pkg::*;

  logic      beat_valid;
  logic      res_ready;
  logic      fire;
  in_beat_t  beat;
  out_beat_t result;

  // Beat moves from input register to result register
  assign fire = beat_valid && res_ready;

  u2u_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .beat_valid_o (beat_valid),
    .beat_take_i  (fire),
    .beat_o       (beat)
  );

  u2u_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (beat),
    .result_o (result)
  );

  u2u_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (beat_valid),
    .res_ready_o (res_ready),
    .res_i       (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
